@@ src/hkst_pkg.sv @@
// Package: shared types, constants and register codes for the held key sequence trigger.
`timescale 1ns / 1ps

package hkst_pkg;

	// Event and key codes
	localparam logic [4:0] EV_KEY         = 5'd1;
	localparam logic [9:0] KEY_VOL_DN     = 10'd114;
	localparam logic [9:0] KEY_VOL_UP     = 10'd115;
	localparam logic [9:0] KEY_PWR        = 10'd116;
	localparam logic [9:0] KEY_HOME       = 10'd172;
	localparam logic [1:0] KEY_VAL_PRESS  = 2'd1;

	localparam int WATCHED_KEYS = 4;
	localparam int SEQ_STEPS    = 3;
	localparam int DEFINED_KEYS = 4;
	localparam int KEY_COUNT    = (WATCHED_KEYS < DEFINED_KEYS) ? WATCHED_KEYS : DEFINED_KEYS;

	localparam logic [DEFINED_KEYS-1:0][9:0] WATCHED_CODES =
		{KEY_HOME, KEY_PWR, KEY_VOL_UP, KEY_VOL_DN};

	localparam int CODE_W    = 10;
	localparam int PRESS_W   = 4;
	localparam int STEP_W    = 2;
	localparam int CNT_W     = 6;
	localparam int REG_STEPS = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_KEY      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP0_KEY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP1_KEY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP2_KEY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP0_PRESSES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP1_PRESSES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP2_PRESSES = 3'd6;

	typedef struct packed {
		logic [4:0]        event_kind;
		logic [CODE_W-1:0] key_id;
		logic [1:0]        key_value;
	} in_word_t;

	typedef struct packed {
		logic              dump_request;
		logic [STEP_W-1:0] progress_step;
		logic [CNT_W-1:0]  progress_count;
	} out_word_t;

	typedef struct packed {
		logic [CODE_W-1:0]                 hold_key;
		logic [REG_STEPS-1:0][CODE_W-1:0]  step_key;
		logic [REG_STEPS-1:0][PRESS_W-1:0] step_presses;
	} cfg_t;

	// Classified event, as queued between front and back
	typedef struct packed {
		logic                 watched;
		logic [KEY_COUNT-1:0] key_bit;
		logic                 is_hold;
		logic                 is_press;
		logic [SEQ_STEPS-1:0] step_hit;
	} cls_t;

endpackage

@@ src/hkst_front.sv @@
// Front end: accepts input words and classifies each event against the watched keys.
`timescale 1ns / 1ps

module hkst_front (
	input  logic              in_valid,
	output logic              in_stall,
	input  hkst_pkg::in_word_t in_word,
	input  hkst_pkg::cfg_t    cfg,
	input  logic              q_full,
	output logic              push,
	output hkst_pkg::cls_t    cls
);

	always_comb begin
		cls = '0;
		if (in_word.event_kind == hkst_pkg::EV_KEY) begin
			for (int i = 0; i < hkst_pkg::KEY_COUNT; i++) begin
				if (in_word.key_id == hkst_pkg::WATCHED_CODES[i]) cls.key_bit[i] = 1'b1;
			end
		end
		cls.watched  = |cls.key_bit;
		cls.is_hold  = (in_word.key_id == cfg.hold_key);
		cls.is_press = (in_word.key_value == hkst_pkg::KEY_VAL_PRESS);
		for (int j = 0; j < hkst_pkg::SEQ_STEPS; j++) begin
			cls.step_hit[j] = (in_word.key_id == cfg.step_key[j]);
		end
	end

	// Hold the source off only when the queue has no room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

endmodule

@@ src/hkst_queue.sv @@
// Short queue of classified events between front and back.
`timescale 1ns / 1ps

module hkst_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hkst_pkg::cls_t push_data,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output hkst_pkg::cls_t head
);

	hkst_pkg::cls_t                entry_q [hkst_pkg::QUEUE_DEPTH];
	logic [hkst_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [hkst_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [hkst_pkg::QCNT_W-1:0]   count_q;

	localparam logic [hkst_pkg::QPTR_W-1:0] LAST_PTR = hkst_pkg::QPTR_W'(hkst_pkg::QUEUE_DEPTH - 1);
	localparam logic [hkst_pkg::QCNT_W-1:0] FULL_CNT = hkst_pkg::QCNT_W'(hkst_pkg::QUEUE_DEPTH);

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + hkst_pkg::QPTR_W'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + hkst_pkg::QPTR_W'(1);
			if (push && !pop) count_q <= count_q + hkst_pkg::QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - hkst_pkg::QCNT_W'(1);
		end
	end

endmodule

@@ src/hkst_back.sv @@
// Back end: key state, sequence tracking and the output word register.
`timescale 1ns / 1ps

module hkst_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hkst_pkg::cfg_t     cfg,
	input  logic               q_not_empty,
	input  hkst_pkg::cls_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output hkst_pkg::out_word_t out_word
);

	localparam logic [hkst_pkg::STEP_W-1:0] LAST_STEP = hkst_pkg::STEP_W'(hkst_pkg::SEQ_STEPS - 1);

	logic [hkst_pkg::KEY_COUNT-1:0] flags_q, flags_d;
	logic                           hold_q, hold_d;
	logic [hkst_pkg::STEP_W-1:0]    step_q, step_d;
	logic [hkst_pkg::CNT_W-1:0]     count_q, count_d;
	logic                           dump;
	logic                           out_valid_q;
	hkst_pkg::out_word_t            out_word_q;

	logic [hkst_pkg::SEQ_STEPS-1:0][hkst_pkg::CNT_W-1:0] cum;
	logic [hkst_pkg::CNT_W-1:0]                          cap;

	// Running press totals per step and the count cap
	always_comb begin
		cum[0] = hkst_pkg::CNT_W'(cfg.step_presses[0]);
		for (int j = 1; j < hkst_pkg::SEQ_STEPS; j++) begin
			cum[j] = cum[j-1] + hkst_pkg::CNT_W'(cfg.step_presses[j]);
		end
		cap = (cum[hkst_pkg::SEQ_STEPS-1] == '0) ? '0
			: cum[hkst_pkg::SEQ_STEPS-1] - hkst_pkg::CNT_W'(1);
	end

	assign pop = q_not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		logic                       already;
		logic                       hit;
		logic [hkst_pkg::CNT_W-1:0] cum_sel;
		flags_d = flags_q;
		hold_d  = hold_q;
		step_d  = step_q;
		count_d = count_q;
		dump    = 1'b0;
		hit     = 1'b0;
		cum_sel = '0;
		already = head.is_hold ? hold_q : |(flags_q & head.key_bit);
		if (head.watched) begin
			if (head.is_press) begin
				if (!already) begin
					flags_d = flags_q | head.key_bit;
					if (head.is_hold) begin
						hold_d = 1'b1;
					end else if (hold_q) begin
						for (int j = 0; j < hkst_pkg::SEQ_STEPS; j++) begin
							if (step_q == hkst_pkg::STEP_W'(j)) hit = head.step_hit[j];
						end
						if (hit) begin
							if (count_q < cap) count_d = count_q + hkst_pkg::CNT_W'(1);
							else dump = 1'b1;
						end else begin
							count_d = '0;
							step_d  = '0;
						end
						for (int j = 0; j < hkst_pkg::SEQ_STEPS; j++) begin
							if (step_d == hkst_pkg::STEP_W'(j)) cum_sel = cum[j];
						end
						if (count_d == cum_sel) begin
							if (step_d < LAST_STEP) step_d = step_d + hkst_pkg::STEP_W'(1);
							else dump = 1'b1;
						end
					end
				end
			end else begin
				flags_d = flags_q & ~head.key_bit;
				if (head.is_hold) begin
					hold_d  = 1'b0;
					step_d  = '0;
					count_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			hold_q      <= 1'b0;
			step_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				flags_q     <= flags_d;
				hold_q      <= hold_d;
				step_q      <= step_d;
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_word_q.dump_request   <= dump;
			out_word_q.progress_step  <= step_d;
			out_word_q.progress_count <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

@@ src/held_key_sequence_trigger_unit.sv @@
// Top level: configuration registers and the front, queue and back of the sequence trigger.
`timescale 1ns / 1ps

// Held key sequence trigger.
// Input channel: in_valid / in_stall / in_word carry one key event per word. A word is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall / out_word carry one result word per input word,
// in order: dump_request, the sequence step and the match count after the event.
// Throughput: one word per cycle while the receiver does not stall. A word taken at an edge
// waits in the two-entry event queue and is loaded into the output register once that
// register is empty or the receiver is not stalling.
// The sequence state update is combinational in the back end and registered on each pop,
// so a new event can follow every cycle while the output is not stalled.
// When the receiver stalls, the output word holds, the queue fills, and once it is full
// in_stall rises until the receiver takes a word again.
// Configuration: cfg_write_en with cfg_index and cfg_data writes one register per edge;
// write only while idle. Indexes beyond the last register are dropped.
// Reset: all keys up, hold key released, step and count zero, queue empty, registers at
// their reset values (hold key 115, step keys 114/116/114, three presses per step).
module held_key_sequence_trigger_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  hkst_pkg::in_word_t                   in_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output hkst_pkg::out_word_t                  out_word,
	input  logic                                 cfg_write_en,
	input  logic [hkst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hkst_pkg::CFG_DAT_W-1:0]       cfg_data
);

	hkst_pkg::cfg_t cfg_q;
	hkst_pkg::cls_t cls;
	hkst_pkg::cls_t head;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_not_empty;

	// Configuration registers; narrow fields take the low bits of the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_key        <= hkst_pkg::KEY_VOL_UP;
			cfg_q.step_key[0]     <= hkst_pkg::KEY_VOL_DN;
			cfg_q.step_key[1]     <= hkst_pkg::KEY_PWR;
			cfg_q.step_key[2]     <= hkst_pkg::KEY_VOL_DN;
			cfg_q.step_presses[0] <= hkst_pkg::PRESS_W'(3);
			cfg_q.step_presses[1] <= hkst_pkg::PRESS_W'(3);
			cfg_q.step_presses[2] <= hkst_pkg::PRESS_W'(3);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				hkst_pkg::REG_HOLD_KEY:      cfg_q.hold_key        <= cfg_data;
				hkst_pkg::REG_STEP0_KEY:     cfg_q.step_key[0]     <= cfg_data;
				hkst_pkg::REG_STEP1_KEY:     cfg_q.step_key[1]     <= cfg_data;
				hkst_pkg::REG_STEP2_KEY:     cfg_q.step_key[2]     <= cfg_data;
				hkst_pkg::REG_STEP0_PRESSES: cfg_q.step_presses[0] <= cfg_data[hkst_pkg::PRESS_W-1:0];
				hkst_pkg::REG_STEP1_PRESSES: cfg_q.step_presses[1] <= cfg_data[hkst_pkg::PRESS_W-1:0];
				hkst_pkg::REG_STEP2_PRESSES: cfg_q.step_presses[2] <= cfg_data[hkst_pkg::PRESS_W-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	// Classify each event as it arrives
	hkst_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.cls      (cls)
	);

	// Decouple the front from output back-pressure
	hkst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	// Advance key and sequence state, one event per cycle unless the output stalls
	hkst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word)
	);

endmodule
